>>> hdl/ttd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_pkg: shared types and decode helpers for the telemetry deframer
// Item structs, tag codes, record sizes and the tag letter decode.
// ----------------------------------------------------------------------------
package ttd_pkg;

  // Record body sizes
  localparam int unsigned CELL_COUNT     = 4;
  localparam int unsigned SERVO_COUNT    = 4;
  localparam int unsigned COMMAND_LENGTH = 8;

  // Tag letters on the wire
  localparam logic [7:0] CHR_T = "T";
  localparam logic [7:0] CHR_N = "N";
  localparam logic [7:0] CHR_E = "E";
  localparam logic [7:0] CHR_L = "L";
  localparam logic [7:0] CHR_D = "D";
  localparam logic [7:0] CHR_A = "A";
  localparam logic [7:0] CHR_R = "R";
  localparam logic [7:0] CHR_P = "P";
  localparam logic [7:0] CHR_Y = "Y";
  localparam logic [7:0] CHR_M = "M";
  localparam logic [7:0] CHR_V = "V";
  localparam logic [7:0] CHR_H = "H";
  localparam logic [7:0] CHR_K = "K";
  localparam logic [7:0] CHR_S = "S";
  localparam logic [7:0] CHR_C = "C";
  localparam logic [7:0] CHR_F = "F";

  typedef enum logic [3:0] {
    TAG_T = 4'd0,  TAG_N = 4'd1,  TAG_E = 4'd2,  TAG_L = 4'd3,
    TAG_D = 4'd4,  TAG_A = 4'd5,  TAG_R = 4'd6,  TAG_P = 4'd7,
    TAG_Y = 4'd8,  TAG_M = 4'd9,  TAG_V = 4'd10, TAG_H = 4'd11,
    TAG_K = 4'd12, TAG_S = 4'd13, TAG_C = 4'd14, TAG_F = 4'd15
  } tag_e;

  // Element size as a byte count mod 4 (a 4-byte word wraps to zero)
  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_BYTE = 2'd1;
  localparam logic [1:0] SIZE_HALF = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_packet;
  } in_t;

  typedef struct packed {
    logic [3:0]  tag_code;
    logic [3:0]  element_index;
    logic [31:0] element_value;
    logic        record_done;
    logic        truncated;
  } out_t;

  // Tag letter decode
  typedef struct packed {
    logic known;
    tag_e tag;
  } tag_dec_t;

  function automatic tag_dec_t tag_of(logic [7:0] b);
    tag_dec_t r;
    r.known = 1'b1;
    r.tag   = TAG_T;
    case (b)
      CHR_T:   r.tag = TAG_T;
      CHR_N:   r.tag = TAG_N;
      CHR_E:   r.tag = TAG_E;
      CHR_L:   r.tag = TAG_L;
      CHR_D:   r.tag = TAG_D;
      CHR_A:   r.tag = TAG_A;
      CHR_R:   r.tag = TAG_R;
      CHR_P:   r.tag = TAG_P;
      CHR_Y:   r.tag = TAG_Y;
      CHR_M:   r.tag = TAG_M;
      CHR_V:   r.tag = TAG_V;
      CHR_H:   r.tag = TAG_H;
      CHR_K:   r.tag = TAG_K;
      CHR_S:   r.tag = TAG_S;
      CHR_C:   r.tag = TAG_C;
      CHR_F:   r.tag = TAG_F;
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] elem_size(tag_e t);
    logic [1:0] s;
    case (t)
      TAG_L, TAG_D, TAG_A, TAG_S, TAG_C: s = SIZE_HALF;
      TAG_F:                             s = SIZE_BYTE;
      default:                           s = SIZE_WORD;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] elem_total(tag_e t);
    logic [4:0] n;
    case (t)
      TAG_L:   n = 5'(CELL_COUNT);
      TAG_D:   n = 5'(SERVO_COUNT);
      TAG_F:   n = 5'(COMMAND_LENGTH);
      default: n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

>>> hdl/ttd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttd_parser: record parse state and per-byte decode
// Tracks tag, byte and element position; builds one result per finished
// element or one truncation result when the packet ends inside a record.
// ----------------------------------------------------------------------------
module ttd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  ttd_pkg::in_t  item_i,
  output logic          res_valid_o,
  output ttd_pkg::out_t res_o
);
  import ttd_pkg::*;

  logic        in_body_q, in_body_d;
  tag_e        tag_q, tag_d;
  logic [1:0]  bie_q, bie_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] word_q, word_d;

  tag_dec_t    dec;
  logic [1:0]  size;
  logic [4:0]  total;
  logic [1:0]  bie_n;
  logic [3:0]  cnt_n;
  logic [31:0] word_n;
  logic        elem_done;
  logic        rec_done;

  assign dec       = tag_of(item_i.rx_byte);
  assign size      = elem_size(tag_q);
  assign total     = elem_total(tag_q);
  // little-endian assembly of the current element
  assign word_n    = word_q | ({24'd0, item_i.rx_byte} << {bie_q, 3'b000});
  assign bie_n     = bie_q + 2'd1;
  assign elem_done = (bie_n == size);
  assign rec_done  = elem_done && (({1'b0, cnt_q} + 5'd1) == total);
  assign cnt_n     = elem_done ? cnt_q + 4'd1 : cnt_q;

  // next state and result
  always_comb begin
    in_body_d   = in_body_q;
    tag_d       = tag_q;
    bie_d       = bie_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (!in_body_q) begin
        // expecting a tag; unknown letters are dropped
        if (dec.known) begin
          tag_d  = dec.tag;
          bie_d  = 2'd0;
          cnt_d  = 4'd0;
          word_d = '0;
          if (item_i.last_in_packet) begin
            // tag with no body
            res_valid_o    = 1'b1;
            res_o.tag_code = dec.tag;
            res_o.truncated = 1'b1;
          end else begin
            in_body_d = 1'b1;
          end
        end
      end else begin
        if (elem_done) begin
          bie_d  = 2'd0;
          word_d = '0;
          cnt_d  = cnt_n;
        end else begin
          bie_d  = bie_n;
          word_d = word_n;
        end
        if (item_i.last_in_packet && !rec_done) begin
          // packet ended mid-record: report and clear
          res_valid_o         = 1'b1;
          res_o.tag_code      = tag_q;
          res_o.element_index = cnt_n;
          res_o.truncated     = 1'b1;
          in_body_d           = 1'b0;
          tag_d               = TAG_T;
          bie_d               = 2'd0;
          cnt_d               = 4'd0;
          word_d              = '0;
        end else begin
          if (rec_done) begin
            in_body_d = 1'b0;
          end
          if (elem_done) begin
            res_valid_o         = 1'b1;
            res_o.tag_code      = tag_q;
            res_o.element_index = cnt_q;
            res_o.element_value = word_n;
            res_o.record_done   = rec_done;
          end
        end
      end
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      tag_q     <= TAG_T;
      bie_q     <= 2'd0;
      cnt_q     <= 4'd0;
      word_q    <= '0;
    end else begin
      in_body_q <= in_body_d;
      tag_q     <= tag_d;
      bie_q     <= bie_d;
      cnt_q     <= cnt_d;
      word_q    <= word_d;
    end
  end

  // end of packet always returns to tag hunting
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_in_packet |=> !in_body_q)
    else $error("record still open after last byte");

  // a completed record closes the body
  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.record_done |=> !in_body_q)
    else $error("record still open after record_done");

  // byte position stays inside the element
  a_byte_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> (size == SIZE_WORD) || (bie_q < size))
    else $error("byte position beyond element size");

  // element count stays inside the record
  a_elem_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> ({1'b0, cnt_q} < total))
    else $error("element count beyond record length");

endmodule

>>> hdl/tagged_telemetry_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_telemetry_deframer: tagged telemetry packet parser
// Splits a received byte stream into tagged records and reports each element.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_ready_o, one packet byte per item with a
//                 last-byte mark.
//   out channel : out_valid_o / out_ready_i, one item per finished element
//                 (tag, index, little-endian value, record_done) or one
//                 truncated item when the packet ends inside a record.
//   Path: a byte accepted into the input register is decoded and its result
//   is written to the output register, which drives out_valid_o. Throughput
//   is one byte per cycle while the output is not stalled; every byte is
//   decoded in one pass from the input register to the output register, bytes that give no result included.
//   Reset: both registers empty, parser waiting for a tag letter.
//   Stall: a held output item keeps its value; the input register holds one
//   more byte, then in_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
module tagged_telemetry_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ttd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ttd_pkg::out_t out_data_o
);
  import ttd_pkg::*;

  logic in_vld_q, in_vld_d;
  in_t  in_q;
  logic out_vld_q, out_vld_d;
  out_t out_q;

  logic out_free;
  logic step;
  logic res_valid;
  out_t res;

  // handshake
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || step;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;
  assign out_vld_d  = out_free ? (step && res_valid) : out_vld_q;

  ttd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
